// ----- design/dsu_pkg.sv -----
// Shared types and constants for the disjoint-set union-find core.
// Request codes, engine state encoding and the request/result records.
// No dependencies.
package dsu_pkg;

    // default element count of the parent table
    localparam int N_ELEMENTS_DEF = 1024;

    // field widths of one request and one result item
    localparam int ELEM_W  = 10;
    localparam int TOTAL_W = 11;
    localparam int KIND_W  = 2;

    // request codes; the unused code behaves as a find
    localparam logic [KIND_W-1:0] REQ_UNION     = 2'd0;
    localparam logic [KIND_W-1:0] REQ_FIND      = 2'd1;
    localparam logic [KIND_W-1:0] REQ_CONNECTED = 2'd2;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_GRAND,
        ST_DONE
    } dsu_state_t;

    // one request item as the engine sees it
    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
    } dsu_req_t;

    // one result item, already masked to the field widths
    typedef struct packed {
        logic [TOTAL_W-1:0] set_total;
        logic               merged;
        logic               same_set;
        logic [ELEM_W-1:0]  root_a;
    } dsu_res_t;

endpackage

// ----- design/dsu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// No dependencies.
module dsu_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dsu_engine.sv -----
// Union-find sequencer: clearing pass, root walks with path halving,
// linking and set counting, all through one read and one write RAM port.
// Depends on dsu_pkg.
module dsu_engine #(
    parameter int N_ELEMENTS = dsu_pkg::N_ELEMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  dsu_pkg::dsu_req_t             req,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output dsu_pkg::dsu_res_t             res,
    // parent table port
    output logic                          ram_we,
    output logic [$clog2(N_ELEMENTS)-1:0] ram_waddr,
    output logic [$clog2(N_ELEMENTS)-1:0] ram_wdata,
    output logic [$clog2(N_ELEMENTS)-1:0] ram_raddr,
    input  logic [$clog2(N_ELEMENTS)-1:0] ram_rdata
);

    localparam int IW = $clog2(N_ELEMENTS);
    localparam int CW = $clog2(N_ELEMENTS + 1);
    localparam int RW = (IW > dsu_pkg::ELEM_W) ? IW : dsu_pkg::ELEM_W;
    localparam int TW = (CW > dsu_pkg::TOTAL_W) ? CW : dsu_pkg::TOTAL_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(N_ELEMENTS - 1);

    dsu_pkg::dsu_state_t state_reg, state_next;

    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] x_reg, x_next;
    logic [IW-1:0] b_reg, b_next;
    logic [IW-1:0] ra_reg, ra_next;
    logic [IW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          phase_reg, phase_next;
    logic          union_reg, union_next;
    logic          conn_reg, conn_next;
    logic          same_reg, same_next;
    logic          merged_reg, merged_next;

    logic [IW-1:0] a_in;
    logic [IW-1:0] b_in;
    logic          accept;
    logic          is_root;
    logic          two_walks;
    logic [RW-1:0] root_wide;
    logic [TW-1:0] total_wide;

    // out-of-range indexes saturate to the last element
    function automatic logic [IW-1:0] clamp_idx(input logic [dsu_pkg::ELEM_W-1:0] v);
        logic [IW-1:0] r;
        if (32'(v) >= 32'(N_ELEMENTS))
        begin
            r = LAST_IDX;
        end
        else
        begin
            r = IW'(v);
        end
        return r;
    endfunction

    assign a_in      = clamp_idx(req.elem_a);
    assign b_in      = clamp_idx(req.elem_b);
    assign accept    = req_valid && req_ready;
    assign is_root   = (ram_rdata == x_reg);
    assign two_walks = union_reg || conn_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsu_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            dsu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dsu_pkg::ST_CHECK;
                end
            end
            dsu_pkg::ST_CHECK:
            begin
                if (!is_root)
                begin
                    state_next = dsu_pkg::ST_GRAND;
                end
                else if (phase_reg || !two_walks)
                begin
                    state_next = dsu_pkg::ST_DONE;
                end
            end
            dsu_pkg::ST_GRAND:
            begin
                state_next = dsu_pkg::ST_CHECK;
            end
            dsu_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dsu_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        clr_next    = clr_reg;
        x_next      = x_reg;
        b_next      = b_reg;
        ra_next     = ra_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        union_next  = union_reg;
        conn_next   = conn_reg;
        same_next   = same_reg;
        merged_next = merged_reg;
        ram_we      = 1'b0;
        ram_waddr   = x_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = x_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            dsu_pkg::ST_CLEAR:
            begin
                // every entry becomes its own root
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = clr_reg;
                clr_next  = clr_reg + IW'(1);
            end
            dsu_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                ram_raddr = a_in;
                if (accept)
                begin
                    x_next     = a_in;
                    b_next     = b_in;
                    phase_next = 1'b0;
                    union_next = (req.req_type == dsu_pkg::REQ_UNION);
                    conn_next  = (req.req_type == dsu_pkg::REQ_CONNECTED);
                end
            end
            dsu_pkg::ST_CHECK:
            begin
                if (!is_root)
                begin
                    // fetch the grandparent
                    ram_raddr = ram_rdata;
                end
                else if (!phase_reg)
                begin
                    // first root found
                    ra_next     = x_reg;
                    root_next   = x_reg;
                    same_next   = 1'b0;
                    merged_next = 1'b0;
                    if (two_walks)
                    begin
                        x_next     = b_reg;
                        ram_raddr  = b_reg;
                        phase_next = 1'b1;
                    end
                end
                else if (union_reg)
                begin
                    // second root found: link first root under it
                    root_next = x_reg;
                    if (ra_reg != x_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = ra_reg;
                        ram_wdata   = x_reg;
                        merged_next = 1'b1;
                        if (cnt_reg > CW'(1))
                        begin
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        same_next = 1'b1;
                    end
                end
                else
                begin
                    root_next = ra_reg;
                    same_next = (ra_reg == x_reg);
                end
            end
            dsu_pkg::ST_GRAND:
            begin
                // halve the path and step to the grandparent
                ram_we    = 1'b1;
                ram_waddr = x_reg;
                ram_wdata = ram_rdata;
                x_next    = ram_rdata;
                ram_raddr = ram_rdata;
            end
            dsu_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsu_pkg::ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= CW'(N_ELEMENTS);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        b_reg      <= b_next;
        ra_reg     <= ra_next;
        root_reg   <= root_next;
        phase_reg  <= phase_next;
        union_reg  <= union_next;
        conn_reg   <= conn_next;
        same_reg   <= same_next;
        merged_reg <= merged_next;
    end

    // mask to the result field widths
    assign root_wide     = RW'(root_reg);
    assign total_wide    = TW'(cnt_reg);
    assign res.root_a    = root_wide[dsu_pkg::ELEM_W-1:0];
    assign res.same_set  = same_reg;
    assign res.merged    = merged_reg;
    assign res.set_total = total_wide[dsu_pkg::TOTAL_W-1:0];

endmodule

// ----- design/disjoint_set_union_find_core.sv -----
// Top level of the disjoint-set union-find core: stream ports, parent
// table RAM, sequencer and the output register.
// Depends on dsu_pkg, dsu_ram and dsu_engine.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------
//  s_       | in  | s_tvalid/s_tready | tuser: req_type; tdata: elem_a, elem_b
//  m_       | out | m_tvalid/m_tready | tdata: root_a, same_set, merged,
//           |     |                   |        set_total
//
// After reset a clearing pass writes every parent entry with s_tready low.
// A find walks from elem_a to its root, a union or connected test walks
// from elem_a and then from elem_b; each halving step of a walk is a
// read of the parent and of the grandparent through the single RAM read
// port. One item is at work at a time; the output register lets the next
// item enter while a result waits on m_tready.
module disjoint_set_union_find_core #(
    parameter int N_ELEMENTS = dsu_pkg::N_ELEMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] elem_a, [19:10] elem_b, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [9:0] root_a, [10] same_set, [11] merged,
                                   // [22:12] set_total, [23] zero
);

    localparam int IW = $clog2(N_ELEMENTS);

    dsu_pkg::dsu_req_t req;
    dsu_pkg::dsu_res_t res;
    dsu_pkg::dsu_res_t out_data_reg;
    logic              out_valid_reg;
    logic              res_valid;
    logic              res_ready;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    // unpack the request item
    assign req.req_type = s_tuser;
    assign req.elem_a   = s_tdata[9:0];
    assign req.elem_b   = s_tdata[19:10];

    dsu_ram #(
        .WIDTH (IW),
        .DEPTH (N_ELEMENTS)
    ) u_parent (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsu_engine #(
        .N_ELEMENTS (N_ELEMENTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register: free when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

// ----- sim/tb_disjoint_set_union_find_core.sv -----
// Self-checking bench for the disjoint-set union-find core.
// A scoreboard class mirrors the parent table and set count to predict each result item.
// Depends on dsu_pkg and disjoint_set_union_find_core.
module tb_disjoint_set_union_find_core;

    // the unused request code, treated by the block as a find
    localparam logic [dsu_pkg::KIND_W-1:0] REQ_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CALM_ITEMS = 150;

    // Tracks the forest and queues the result item each accepted request will give
    class forest_tracker;
        logic [dsu_pkg::ELEM_W-1:0]  link [dsu_pkg::N_ELEMENTS_DEF];
        logic [dsu_pkg::TOTAL_W-1:0] set_count;
        dsu_pkg::dsu_res_t           awaited [$];
        int                          failures;

        function new();
            foreach (link[i])
                link[i] = dsu_pkg::ELEM_W'(i);
            set_count = dsu_pkg::TOTAL_W'(dsu_pkg::N_ELEMENTS_DEF);
            failures = 0;
        endfunction

        function logic [dsu_pkg::ELEM_W-1:0] clamp_elem(logic [dsu_pkg::ELEM_W-1:0] v);
            if (int'(v) >= dsu_pkg::N_ELEMENTS_DEF)
                return dsu_pkg::ELEM_W'(dsu_pkg::N_ELEMENTS_DEF - 1);
            return v;
        endfunction

        // root walk with path halving: each visited node is relinked to its grandparent
        function logic [dsu_pkg::ELEM_W-1:0] walk_to_root(logic [dsu_pkg::ELEM_W-1:0] node);
            logic [dsu_pkg::ELEM_W-1:0] grand;
            int steps;
            steps = 0;
            while (link[node] != node && steps < dsu_pkg::N_ELEMENTS_DEF)
            begin
                grand = link[link[node]];
                link[node] = grand;
                node = grand;
                steps++;
            end
            return node;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string msg);
            failures++;
            $display("MISMATCH: %s", msg);
        endtask

        task note_request(logic [dsu_pkg::KIND_W-1:0] kind, logic [dsu_pkg::ELEM_W-1:0] a,
                          logic [dsu_pkg::ELEM_W-1:0] b);
            dsu_pkg::dsu_res_t res;
            logic [dsu_pkg::ELEM_W-1:0] ia, ib, ra, rb;
            res = '0;
            ia = clamp_elem(a);
            ib = clamp_elem(b);
            if (kind == dsu_pkg::REQ_UNION)
            begin
                ra = walk_to_root(ia);
                rb = walk_to_root(ib);
                if (ra != rb)
                begin
                    link[ra] = rb;
                    res.merged = 1'b1;
                    if (set_count > 1)
                        set_count = set_count - 1'b1;
                end
                else
                begin
                    res.same_set = 1'b1;
                end
                res.root_a = rb;
            end
            else if (kind == dsu_pkg::REQ_CONNECTED)
            begin
                // elem_a is walked first, then elem_b
                ra = walk_to_root(ia);
                rb = walk_to_root(ib);
                res.same_set = (ra == rb);
                res.root_a = ra;
            end
            else
            begin
                // find, and the spare code behaving as a find
                res.root_a = walk_to_root(ia);
            end
            res.set_total = set_count;
            awaited = {awaited, res};
        endtask

        task check_result(logic [23:0] word);
            dsu_pkg::dsu_res_t got, want;
            got = dsu_pkg::dsu_res_t'(word[22:0]);
            if (awaited.size() == 0)
            begin
                report($sformatf("result item %h with nothing awaited", word));
                return;
            end
            want = awaited.pop_front();
            if (got.root_a !== want.root_a)
                report($sformatf("root_a %0d, expected %0d", got.root_a, want.root_a));
            if (got.same_set !== want.same_set)
                report($sformatf("same_set %b, expected %b", got.same_set, want.same_set));
            if (got.merged !== want.merged)
                report($sformatf("merged %b, expected %b", got.merged, want.merged));
            if (got.set_total !== want.set_total)
                report($sformatf("set_total %0d, expected %0d", got.set_total,
                                 want.set_total));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [9:0] elem_a, [19:10] elem_b, rest zero
    logic [1:0]  s_tuser;    // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [9:0] root_a, [10] same_set, [11] merged, [22:12] set_total

    forest_tracker board = new();
    int stall_pct = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int win_base = 0;
    int win_span = 16;

    disjoint_set_union_find_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // offer one request item, with an optional idle burst first
    task automatic send_request(input logic [dsu_pkg::KIND_W-1:0] kind,
                                input logic [dsu_pkg::ELEM_W-1:0] a,
                                input logic [dsu_pkg::ELEM_W-1:0] b);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(kind, a, b);
    endtask

    // mostly elements from a sliding window so that trees grow deep; some over the full range
    function automatic logic [dsu_pkg::ELEM_W-1:0] pick_elem();
        if ($urandom_range(0, 3) == 0)
            return dsu_pkg::ELEM_W'($urandom_range(0, 1023));
        return dsu_pkg::ELEM_W'((win_base + $urandom_range(0, win_span - 1)) % 1024);
    endfunction

    function automatic logic [dsu_pkg::KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return dsu_pkg::REQ_UNION;
        if (r < 75)
            return dsu_pkg::REQ_FIND;
        if (r < 93)
            return dsu_pkg::REQ_CONNECTED;
        return REQ_SPARE;
    endfunction

    task automatic run_directed();
        stall_pct = 15;
        send_request(dsu_pkg::REQ_FIND, 10'd0, 10'd0);
        send_request(dsu_pkg::REQ_FIND, 10'd1023, 10'd1023);
        send_request(REQ_SPARE, 10'd5, 10'd1023);
        send_request(dsu_pkg::REQ_CONNECTED, 10'd0, 10'd1023);
        send_request(dsu_pkg::REQ_UNION, 10'd0, 10'd1023);
        send_request(dsu_pkg::REQ_CONNECTED, 10'd0, 10'd1023);
        // union within one set: no link, counter unchanged
        send_request(dsu_pkg::REQ_UNION, 10'd0, 10'd1023);
        send_request(dsu_pkg::REQ_UNION, 10'd5, 10'd5);
        send_request(dsu_pkg::REQ_UNION, 10'd1023, 10'd0);
        // build a chain 1-2-3-4-5 and let the walks halve it
        send_request(dsu_pkg::REQ_UNION, 10'd1, 10'd2);
        send_request(dsu_pkg::REQ_UNION, 10'd2, 10'd3);
        send_request(dsu_pkg::REQ_UNION, 10'd3, 10'd4);
        send_request(dsu_pkg::REQ_UNION, 10'd4, 10'd5);
        send_request(dsu_pkg::REQ_FIND, 10'd1, 10'd1023);
        send_request(dsu_pkg::REQ_FIND, 10'd1, 10'd0);
        send_request(dsu_pkg::REQ_CONNECTED, 10'd1, 10'd5);
        send_request(dsu_pkg::REQ_CONNECTED, 10'd5, 10'd0);
        // alternating bit patterns
        send_request(dsu_pkg::REQ_UNION, 10'd682, 10'd341);
        send_request(dsu_pkg::REQ_CONNECTED, 10'd341, 10'd682);
        send_request(REQ_SPARE, 10'd682, 10'd0);
        send_request(dsu_pkg::REQ_UNION, 10'd5, 10'd682);
        send_request(dsu_pkg::REQ_FIND, 10'd2, 10'd341);
    endtask

    task automatic run_random();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // a new window and idling level every 50 items, no idling in the last stretch
            if (n % 50 == 0)
            begin
                win_base = $urandom_range(0, 1023);
                win_span = $urandom_range(8, 64);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 8;
                    default: stall_pct = 25;
                endcase
            end
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                stall_pct = 0;
            send_request(pick_kind(), pick_elem(), pick_elem());
        end
    endtask

    // main sequence: reset, stimulus, drain, verdict
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= dsu_pkg::REQ_FIND;
        m_tready <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side: check accepted items, then choose next tready
    initial
    begin
        int hold_left;
        bit held_long;
        hold_left = 0;
        held_long = 1'b0;
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata);
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held_long && results_seen >= 60)
            begin
                // long hold-off so the block fills and stalls its input
                held_long = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                hold_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
design/dsu_pkg.sv
design/dsu_ram.sv
design/dsu_engine.sv
design/disjoint_set_union_find_core.sv
sim/tb_disjoint_set_union_find_core.sv
